>>> sv/assert_macros.svh
// Assertion shorthands used by the checker file dhpd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define DHPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define DHPD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DHPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/dhpd_pkg.sv
`timescale 1ns / 1ps

package dhpd_pkg;

    // Drive direction codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BWD  = 2'd2;

    // Register indexes on the config port
    localparam logic [2:0] REG_KP     = 3'd0;
    localparam logic [2:0] REG_KI     = 3'd1;
    localparam logic [2:0] REG_KD     = 3'd2;
    localparam logic [2:0] REG_DT     = 3'd3;
    localparam logic [2:0] REG_FSAFE  = 3'd4;
    localparam logic [2:0] REG_BSAFE  = 3'd5;
    localparam logic [2:0] REG_TARGET = 3'd6;
    localparam logic [2:0] REG_MAXSPD = 3'd7;

    // Register reset values
    localparam logic [15:0] RST_KP     = 16'd3277;
    localparam logic [15:0] RST_KI     = 16'd410;
    localparam logic [15:0] RST_KD     = 16'd205;
    localparam logic [15:0] RST_DT     = 16'd3277;
    localparam logic [15:0] RST_FSAFE  = 16'd5120;
    localparam logic [15:0] RST_BSAFE  = 16'd5120;
    localparam logic [15:0] RST_TARGET = 16'd7680;
    localparam logic [8:0]  RST_MAXSPD = 9'd200;

    // Drive constants
    localparam logic [10:0] CENTER_US   = 11'd1500;
    localparam logic [8:0]  SPEED_FLOOR = 9'd50;
    localparam logic [15:0] STOP_BAND   = 16'd1280;

    // Derivative divider: (|diff| << 16) / dt, one quotient bit per cycle
    localparam int          DIV_STEPS = 33;
    localparam logic [5:0]  DIV_CNT_INIT = 6'(DIV_STEPS);

    // Shared multiplier operand select
    typedef logic [2:0] t_mul_sel;
    localparam t_mul_sel MUL_IDT  = 3'd0;  // dt * err
    localparam t_mul_sel MUL_KP   = 3'd1;  // kp * err
    localparam t_mul_sel MUL_KILO = 3'd2;  // ki * integral[19:0]
    localparam t_mul_sel MUL_KIHI = 3'd3;  // ki * integral[39:20]
    localparam t_mul_sel MUL_KD   = 3'd4;  // kd * derivative

    typedef struct packed {
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
        logic [15:0] dt;
        logic [15:0] front_safety;
        logic [15:0] back_safety;
        logic [15:0] setpoint;
        logic [8:0]  speed_cap;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic     capture;    // latch input beat
        logic     dir_step;   // update direction, error, start divider
        t_mul_sel mul_sel;
        logic     int_upd;    // integral += dt * err
        logic     p_cap;
        logic     ilo_cap;
        logic     iprod_cap;
        logic     i_cap;
        logic     der_cap;    // saturate quotient, add P + I
        logic     sum_cap;
        logic     mag_cap;
        logic     out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_busy;
        logic out_free;
    } t_stat;

endpackage

>>> sv/dhpd_regs.sv
`timescale 1ns / 1ps

module dhpd_regs import dhpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp           <= RST_KP;
            r_cfg.ki           <= RST_KI;
            r_cfg.kd           <= RST_KD;
            r_cfg.dt           <= RST_DT;
            r_cfg.front_safety <= RST_FSAFE;
            r_cfg.back_safety  <= RST_BSAFE;
            r_cfg.setpoint     <= RST_TARGET;
            r_cfg.speed_cap    <= RST_MAXSPD;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_KP:     r_cfg.kp           <= pwdata[15:0];
                REG_KI:     r_cfg.ki           <= pwdata[15:0];
                REG_KD:     r_cfg.kd           <= pwdata[15:0];
                REG_DT:     r_cfg.dt           <= pwdata[15:0];
                REG_FSAFE:  r_cfg.front_safety <= pwdata[15:0];
                REG_BSAFE:  r_cfg.back_safety  <= pwdata[15:0];
                REG_TARGET: r_cfg.setpoint     <= pwdata[15:0];
                REG_MAXSPD: r_cfg.speed_cap    <= pwdata[8:0];
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_KP:     prdata = {16'd0, r_cfg.kp};
            REG_KI:     prdata = {16'd0, r_cfg.ki};
            REG_KD:     prdata = {16'd0, r_cfg.kd};
            REG_DT:     prdata = {16'd0, r_cfg.dt};
            REG_FSAFE:  prdata = {16'd0, r_cfg.front_safety};
            REG_BSAFE:  prdata = {16'd0, r_cfg.back_safety};
            REG_TARGET: prdata = {16'd0, r_cfg.setpoint};
            REG_MAXSPD: prdata = {23'd0, r_cfg.speed_cap};
        endcase
    end

endmodule

>>> sv/dhpd_div.sv
`timescale 1ns / 1ps

// Restoring divider: quotient of (i_num << 16) / i_den, one bit per cycle.
module dhpd_div import dhpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_busy,
    output logic [32:0] o_quo
);

    logic [5:0]  r_cnt;
    logic [32:0] r_quo;
    logic [15:0] r_rem;
    logic [15:0] r_den;
    logic [16:0] trial;
    logic [16:0] trial_sub;
    logic        fits;

    assign o_busy = (r_cnt != 6'd0);
    assign o_quo  = r_quo;

    // One restoring step
    assign trial     = {r_rem, r_quo[32]};
    assign fits      = (trial >= {1'b0, r_den});
    assign trial_sub = trial - {1'b0, r_den};

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 6'd0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_INIT;
        end else if (o_busy) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    // Dividend shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= {i_num, 16'd0};
            r_rem <= 16'd0;
            r_den <= i_den;
        end else if (o_busy) begin
            r_quo <= {r_quo[31:0], fits};
            r_rem <= fits ? trial_sub[15:0] : trial[15:0];
        end
    end

endmodule

>>> sv/dhpd_dp.sv
`timescale 1ns / 1ps

module dhpd_dp import dhpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [15:0] i_front_distance,
    input  logic [15:0] i_back_distance,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [10:0] o_left_front_us,
    output logic [10:0] o_left_rear_us,
    output logic [10:0] o_right_rear_us,
    output logic [10:0] o_right_front_us,
    output logic [1:0]  o_direction,
    output logic [8:0]  o_speed
);

    // Controller state held across items
    logic [1:0]  r_dir;
    logic [16:0] r_prev_err;
    logic [39:0] r_int;

    // Per-item working registers
    logic [15:0] r_f;
    logic [15:0] r_b;
    logic [16:0] r_err;
    logic        r_diff_neg;
    logic        r_diff_zero;
    logic [48:0] r_prod;
    logic [32:0] r_p;
    logic [35:0] r_ilo;
    logic [55:0] r_iprod;
    logic [40:0] r_i;
    logic [41:0] r_pi;
    logic [31:0] r_der;
    logic [49:0] r_sum;
    logic [8:0]  r_speed;
    logic        r_out_valid;

    logic [1:0]  n_dir;
    logic [15:0] fdiff;
    logic [15:0] bdiff;
    logic [15:0] meas;
    logic [16:0] err;
    logic [17:0] diff;
    logic [17:0] diff_abs;
    logic        div_busy;
    logic [32:0] quo;
    logic [15:0] mul_a;
    logic [31:0] mul_b;
    logic [48:0] mul_p;
    logic [40:0] int_sum;
    logic [39:0] int_sat;
    logic [56:0] iprod_sum;
    logic [55:0] iprod_abs;
    logic [40:0] i_mag;
    logic [31:0] der_sat;
    logic [49:0] sum_abs;
    logic [29:0] mag;
    logic [8:0]  speed;
    logic [10:0] pulse_plus;
    logic [10:0] pulse_minus;

    // Direction rules, highest priority first
    assign fdiff = (r_f >= i_cfg.setpoint) ? (r_f - i_cfg.setpoint)
                                           : (i_cfg.setpoint - r_f);
    assign bdiff = (r_b >= i_cfg.setpoint) ? (r_b - i_cfg.setpoint)
                                           : (i_cfg.setpoint - r_b);

    always_comb begin
        priority if (r_f < i_cfg.front_safety) begin
            n_dir = DIR_BWD;
        end else if (r_b < i_cfg.back_safety) begin
            n_dir = DIR_FWD;
        end else if (r_f < i_cfg.setpoint && r_b > i_cfg.setpoint) begin
            n_dir = DIR_BWD;
        end else if (r_f > i_cfg.setpoint && r_b < i_cfg.setpoint) begin
            n_dir = DIR_FWD;
        end else if (fdiff < STOP_BAND && bdiff < STOP_BAND) begin
            n_dir = DIR_STOP;
        end else begin
            n_dir = r_dir;
        end
    end

    // Error and its change
    assign meas     = (n_dir == DIR_FWD) ? r_f : r_b;
    assign err      = {1'b0, i_cfg.setpoint} - {1'b0, meas};
    assign diff     = {err[16], err} - {r_prev_err[16], r_prev_err};
    assign diff_abs = diff[17] ? (18'd0 - diff) : diff;

    dhpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.dir_step),
        .i_num   (diff_abs[16:0]),
        .i_den   (i_cfg.dt),
        .o_busy  (div_busy),
        .o_quo   (quo)
    );

    // Shared 17x32 signed multiplier
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_IDT: begin
                mul_a = i_cfg.dt;
                mul_b = {{15{r_err[16]}}, r_err};
            end
            MUL_KP: begin
                mul_a = i_cfg.kp;
                mul_b = {{15{r_err[16]}}, r_err};
            end
            MUL_KILO: begin
                mul_a = i_cfg.ki;
                mul_b = {12'd0, r_int[19:0]};
            end
            MUL_KIHI: begin
                mul_a = i_cfg.ki;
                mul_b = {{12{r_int[39]}}, r_int[39:20]};
            end
            MUL_KD: begin
                mul_a = i_cfg.kd;
                mul_b = r_der;
            end
            default: begin
                mul_a = 16'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p = 49'($signed({1'b0, mul_a}) * $signed(mul_b));

    // Integral with 40-bit saturation
    assign int_sum = {r_int[39], r_int} + r_prod[40:0];
    assign int_sat = (int_sum[40] != int_sum[39])
                   ? (int_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}})
                   : int_sum[39:0];

    // ki * integral from two partial products, magnitude shifted by 16
    assign iprod_sum = {r_prod[36:0], 20'd0} + {21'd0, r_ilo};
    assign iprod_abs = r_iprod[55] ? (56'd0 - r_iprod) : r_iprod;
    assign i_mag     = {1'b0, iprod_abs[55:16]};

    // Signed, saturated derivative from the quotient magnitude
    always_comb begin
        priority if (i_cfg.dt == 16'd0) begin
            if (r_diff_zero) begin
                der_sat = 32'd0;
            end else begin
                der_sat = r_diff_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
        end else if (r_diff_neg) begin
            der_sat = (quo > 33'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - quo[31:0]);
        end else begin
            der_sat = (quo > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
        end
    end

    // Output magnitude and clamp
    assign sum_abs = r_sum[49] ? (50'd0 - r_sum) : r_sum;
    assign mag     = sum_abs[49:20];

    always_comb begin
        priority if (mag < 30'(SPEED_FLOOR)) begin
            speed = SPEED_FLOOR;
        end else if (mag > 30'(i_cfg.speed_cap)) begin
            speed = i_cfg.speed_cap;
        end else begin
            speed = mag[8:0];
        end
    end

    assign pulse_plus  = CENTER_US + 11'(r_speed);
    assign pulse_minus = CENTER_US - 11'(r_speed);

    // State kept across items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir      <= DIR_STOP;
            r_prev_err <= 17'd0;
            r_int      <= 40'd0;
        end else begin
            if (i_cmd.dir_step) begin
                r_dir      <= n_dir;
                r_prev_err <= err;
            end
            if (i_cmd.int_upd) begin
                r_int <= int_sat;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (i_cmd.capture) begin
            r_f <= i_front_distance;
            r_b <= i_back_distance;
        end
        if (i_cmd.dir_step) begin
            r_err       <= err;
            r_diff_neg  <= diff[17];
            r_diff_zero <= (diff == 18'd0);
        end
        if (i_cmd.p_cap) begin
            r_p <= r_prod[32:0];
        end
        if (i_cmd.ilo_cap) begin
            r_ilo <= r_prod[35:0];
        end
        if (i_cmd.iprod_cap) begin
            r_iprod <= iprod_sum[55:0];
        end
        if (i_cmd.i_cap) begin
            r_i <= r_iprod[55] ? (41'd0 - i_mag) : i_mag;
        end
        if (i_cmd.der_cap) begin
            r_der <= der_sat;
            r_pi  <= {{9{r_p[32]}}, r_p} + {r_i[40], r_i};
        end
        if (i_cmd.sum_cap) begin
            r_sum <= {{8{r_pi[41]}}, r_pi} + {r_prod[48], r_prod};
        end
        if (i_cmd.mag_cap) begin
            r_speed <= speed;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_direction <= r_dir;
            o_speed     <= r_speed;
            unique case (r_dir)
                DIR_FWD: begin
                    o_left_front_us  <= pulse_plus;
                    o_left_rear_us   <= pulse_plus;
                    o_right_rear_us  <= pulse_minus;
                    o_right_front_us <= pulse_minus;
                end
                DIR_BWD: begin
                    o_left_front_us  <= pulse_minus;
                    o_left_rear_us   <= pulse_minus;
                    o_right_rear_us  <= pulse_plus;
                    o_right_front_us <= pulse_plus;
                end
                default: begin
                    o_left_front_us  <= CENTER_US;
                    o_left_rear_us   <= CENTER_US;
                    o_right_rear_us  <= CENTER_US;
                    o_right_front_us <= CENTER_US;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_stat.div_busy = div_busy;
    assign o_stat.out_free = !r_out_valid || !i_stall;

endmodule

>>> sv/dhpd_ctrl.sv
`timescale 1ns / 1ps

module dhpd_ctrl import dhpd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DIR      = 4'd1;
    localparam logic [3:0] S_M_IDT    = 4'd2;
    localparam logic [3:0] S_M_KP     = 4'd3;
    localparam logic [3:0] S_M_KILO   = 4'd4;
    localparam logic [3:0] S_M_KIHI   = 4'd5;
    localparam logic [3:0] S_I_SUM    = 4'd6;
    localparam logic [3:0] S_I_ABS    = 4'd7;
    localparam logic [3:0] S_DIV_WAIT = 4'd8;
    localparam logic [3:0] S_DER      = 4'd9;
    localparam logic [3:0] S_M_KD     = 4'd10;
    localparam logic [3:0] S_SUM      = 4'd11;
    localparam logic [3:0] S_MAG      = 4'd12;
    localparam logic [3:0] S_OUT      = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = MUL_KD;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DIR;
                end
            end
            S_DIR: begin
                o_cmd.dir_step = 1'b1;
                n_state        = S_M_IDT;
            end
            S_M_IDT: begin
                o_cmd.mul_sel = MUL_IDT;
                n_state       = S_M_KP;
            end
            S_M_KP: begin
                o_cmd.mul_sel = MUL_KP;
                o_cmd.int_upd = 1'b1;
                n_state       = S_M_KILO;
            end
            S_M_KILO: begin
                o_cmd.mul_sel = MUL_KILO;
                o_cmd.p_cap   = 1'b1;
                n_state       = S_M_KIHI;
            end
            S_M_KIHI: begin
                o_cmd.mul_sel = MUL_KIHI;
                o_cmd.ilo_cap = 1'b1;
                n_state       = S_I_SUM;
            end
            S_I_SUM: begin
                o_cmd.iprod_cap = 1'b1;
                n_state         = S_I_ABS;
            end
            S_I_ABS: begin
                o_cmd.i_cap = 1'b1;
                n_state     = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_DER;
                end
            end
            S_DER: begin
                o_cmd.der_cap = 1'b1;
                n_state       = S_M_KD;
            end
            S_M_KD: begin
                o_cmd.mul_sel = MUL_KD;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_cap = 1'b1;
                n_state       = S_MAG;
            end
            S_MAG: begin
                o_cmd.mag_cap = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/distance_hold_pid_drive_unit.sv
// The time from an accepted input beat to o_valid is set by the bit-serial
// derivative divider plus the multiply/sum steps after it. A new beat is
// accepted only once the previous item is done; a held output stall delays
// an item only when the previous result is still in the output register.
// Reset (i_rst_n low, synchronous): gains and limits to their defaults,
// integral, previous error and direction cleared, output register emptied.
`timescale 1ns / 1ps

module distance_hold_pid_drive_unit import dhpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_front_distance,
    input  logic [15:0] i_back_distance,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [10:0] o_left_front_us,
    output logic [10:0] o_left_rear_us,
    output logic [10:0] o_right_rear_us,
    output logic [10:0] o_right_front_us,
    output logic [1:0]  o_direction,
    output logic [8:0]  o_speed
);

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    dhpd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dhpd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    dhpd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_front_distance (i_front_distance),
        .i_back_distance  (i_back_distance),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_left_front_us  (o_left_front_us),
        .o_left_rear_us   (o_left_rear_us),
        .o_right_rear_us  (o_right_rear_us),
        .o_right_front_us (o_right_front_us),
        .o_direction      (o_direction),
        .o_speed          (o_speed)
    );

endmodule

>>> sv/dhpd_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dhpd_checker import dhpd_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [10:0] o_left_front_us,
    input logic [10:0] o_left_rear_us,
    input logic [10:0] o_right_rear_us,
    input logic [10:0] o_right_front_us,
    input logic [1:0]  o_direction,
    input logic [8:0]  o_speed
);

    logic [54:0] out_beat;
    logic        all_center;
    logic        pulse_sym;

    // Whole result beat, for hold checks
    assign out_beat = {o_left_front_us, o_left_rear_us, o_right_rear_us, o_right_front_us,
                       o_direction, o_speed};

    assign all_center = (o_left_front_us == CENTER_US) && (o_right_front_us == CENTER_US)
                     && (o_left_rear_us == CENTER_US) && (o_right_rear_us == CENTER_US);

    assign pulse_sym = (o_left_front_us == o_left_rear_us)
                    && (o_right_front_us == o_right_rear_us)
                    && ((12'(o_left_front_us) + 12'(o_right_front_us)) == 12'd3000);

    // A stalled result beat holds
    `DHPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_beat), "stalled result beat changed")

    // Only one item in flight: an accepted beat closes the input side
    `DHPD_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "input taken while an item is in work")

    // Stopped drive centers every servo
    `DHPD_ASSERT_IMPL(a_stop_center, i_clk, i_rst_n, o_valid && o_direction == DIR_STOP, all_center, "stop beat with off-center pulse")

    // Sides mirror each other around the center pulse
    `DHPD_ASSERT_IMPL(a_pulse_sym, i_clk, i_rst_n, o_valid, pulse_sym, "servo pulses not symmetric")

endmodule

bind distance_hold_pid_drive_unit dhpd_checker u_dhpd_checker (.*);

>>> dv/tb_distance_hold_pid_drive_unit.sv
`timescale 1ns / 1ps

module tb_distance_hold_pid_drive_unit;
    import dhpd_pkg::*;

    // Saturation bounds of the integral and derivative terms
    localparam longint ACC_MAX = 64'sd549755813887;
    localparam longint ACC_MIN = -ACC_MAX - 1;
    localparam longint DER_MAX = 64'sd2147483647;
    localparam longint DER_MIN = -DER_MAX - 1;
    localparam int     SETTLE_CYCLES = 45;

    typedef struct packed {
        logic [10:0] left_front_us;
        logic [10:0] left_rear_us;
        logic [10:0] right_rear_us;
        logic [10:0] right_front_us;
        logic [1:0]  direction;
        logic [8:0]  speed;
    } t_drive_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid, o_stall;
    logic [15:0] i_front_distance, i_back_distance;
    logic        o_valid, i_stall;
    logic [10:0] o_left_front_us, o_left_rear_us, o_right_rear_us, o_right_front_us;
    logic [1:0]  o_direction;
    logic [8:0]  o_speed;

    // Controller shadow: register copy plus loop state
    t_cfg        gain_cfg;
    longint      integ_acc;
    longint      err_prev;
    logic [1:0]  heading;

    t_drive_cmd  drive_cmd_q[$];
    int          mismatch_count = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          hold_left = 0;

    always #2 i_clk = ~i_clk;

    distance_hold_pid_drive_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_front_distance (i_front_distance),
        .i_back_distance  (i_back_distance),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_left_front_us  (o_left_front_us),
        .o_left_rear_us   (o_left_rear_us),
        .o_right_rear_us  (o_right_rear_us),
        .o_right_front_us (o_right_front_us),
        .o_direction      (o_direction),
        .o_speed          (o_speed)
    );

    // One control tick: direction rules, PID step, speed clamp, pulse widths
    function automatic t_drive_cmd pid_drive_step(input logic [15:0] fd, input logic [15:0] bd);
        t_drive_cmd cmd;
        longint f, b, t, fs, bs, band, dtv, kpv, kiv, kdv, msv, lo, ctr;
        longint err, diff, der, prod, imag, sum, mag, spd, lft, rgt;
        f = fd;
        b = bd;
        t = gain_cfg.setpoint;
        fs = gain_cfg.front_safety;
        bs = gain_cfg.back_safety;
        band = STOP_BAND;
        dtv = gain_cfg.dt;
        kpv = gain_cfg.kp;
        kiv = gain_cfg.ki;
        kdv = gain_cfg.kd;
        msv = gain_cfg.speed_cap;
        lo = SPEED_FLOOR;
        ctr = CENTER_US;

        // safety first, then straddling, then stop band, else hold
        if (f < fs) begin
            heading = DIR_BWD;
        end else if (b < bs) begin
            heading = DIR_FWD;
        end else if (f < t && b > t) begin
            heading = DIR_BWD;
        end else if (f > t && b < t) begin
            heading = DIR_FWD;
        end else if ((f > t ? f - t : t - f) < band && (b > t ? b - t : t - b) < band) begin
            heading = DIR_STOP;
        end

        err = t - ((heading == DIR_FWD) ? f : b);

        // integral with 40-bit saturation
        integ_acc = integ_acc + err * dtv;
        if (integ_acc > ACC_MAX) begin
            integ_acc = ACC_MAX;
        end else if (integ_acc < ACC_MIN) begin
            integ_acc = ACC_MIN;
        end

        // derivative; zero period pins it to the sign of the change
        diff = err - err_prev;
        if (dtv == 0) begin
            der = (diff > 0) ? DER_MAX : ((diff < 0) ? DER_MIN : 0);
        end else begin
            der = (diff * 65536) / dtv;
            if (der > DER_MAX) der = DER_MAX;
            else if (der < DER_MIN) der = DER_MIN;
        end
        err_prev = err;

        // I term magnitude truncates toward zero
        prod = kiv * integ_acc;
        imag = (prod < 0 ? -prod : prod) >>> 16;
        sum = kpv * err + (prod < 0 ? -imag : imag) + kdv * der;
        mag = (sum < 0 ? -sum : sum) >>> 20;

        // lower bound wins over the speed cap
        if (mag < lo) spd = lo;
        else if (mag > msv) spd = msv;
        else spd = mag;

        if (heading == DIR_FWD) begin
            lft = ctr + spd;
            rgt = ctr - spd;
        end else if (heading == DIR_BWD) begin
            lft = ctr - spd;
            rgt = ctr + spd;
        end else begin
            lft = ctr;
            rgt = ctr;
        end

        cmd.left_front_us  = 11'(lft);
        cmd.left_rear_us   = 11'(lft);
        cmd.right_rear_us  = 11'(rgt);
        cmd.right_front_us = 11'(rgt);
        cmd.direction      = heading;
        cmd.speed          = 9'(spd);
        return cmd;
    endfunction

    // Idle run length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 4);
        if (r < 95) return $urandom_range(5, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [15:0] near_value(input logic [15:0] center, input int span);
        int v;
        v = int'(center) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    function automatic void cmp_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
        if (got !== want) begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Result beat check against the oldest prediction
    function automatic void check_beat();
        t_drive_cmd want;
        if (drive_cmd_q.size() == 0) begin
            $error("result beat with no prediction pending");
            mismatch_count++;
            return;
        end
        want = drive_cmd_q.pop_front();
        cmp_field("left_front_us", want.left_front_us, o_left_front_us);
        cmp_field("left_rear_us", want.left_rear_us, o_left_rear_us);
        cmp_field("right_rear_us", want.right_rear_us, o_right_rear_us);
        cmp_field("right_front_us", want.right_front_us, o_right_front_us);
        cmp_field("direction", want.direction, o_direction);
        cmp_field("speed", want.speed, o_speed);
    endfunction

    // Output side sampled mid-cycle; the beat is taken at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) check_beat();
    end

    // Receiver stall generator, with a counted hold-off on request
    initial begin : rx_stall_gen
        int  run;
        bit  stalling;
        run = 0;
        stalling = 1'b0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!rx_idle_on) begin
                run = 0;
                i_stall <= 1'b0;
            end else begin
                if (run == 0) begin
                    stalling = ($urandom_range(0, 2) == 0);
                    run = stalling ? idle_len() : $urandom_range(1, 12);
                end
                run--;
                i_stall <= stalling;
            end
        end
    end

    // Send one input beat; predict on acceptance
    task automatic send_beat(input logic [15:0] fd, input logic [15:0] bd);
        int gap;
        bit taken;
        gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_front_distance <= fd;
        i_back_distance <= bd;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        drive_cmd_q.push_back(pid_drive_step(fd, bd));
    endtask

    // Wait until every predicted beat came back and the pipe is quiet
    task automatic wait_drain();
        i_valid <= 1'b0;
        while (drive_cmd_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write: setup then access, then the bus returns to idle
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        bit rdy;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = pready;
            @(posedge i_clk);
        end while (!rdy);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_KP:     gain_cfg.kp = value;
            REG_KI:     gain_cfg.ki = value;
            REG_KD:     gain_cfg.kd = value;
            REG_DT:     gain_cfg.dt = value;
            REG_FSAFE:  gain_cfg.front_safety = value;
            REG_BSAFE:  gain_cfg.back_safety = value;
            REG_TARGET: gain_cfg.setpoint = value;
            REG_MAXSPD: gain_cfg.speed_cap = value[8:0];
            default:    ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] kp, input logic [15:0] ki,
                              input logic [15:0] kd, input logic [15:0] dt,
                              input logic [15:0] fs, input logic [15:0] bs,
                              input logic [15:0] tg, input logic [8:0] ms);
        wait_drain();
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        write_reg(REG_DT, dt);
        write_reg(REG_FSAFE, fs);
        write_reg(REG_BSAFE, bs);
        write_reg(REG_TARGET, tg);
        write_reg(REG_MAXSPD, {7'd0, ms});
    endtask

    // Reset values: every direction rule, plus hold when no rule fires
    task automatic test_direction_rules();
        send_beat(16'd7680, 16'd7680);
        send_beat(16'd4000, 16'd9000);
        send_beat(16'd9000, 16'd4000);
        send_beat(16'd6000, 16'd9000);
        send_beat(16'd9000, 16'd6000);
        send_beat(16'd7000, 16'd8000);
        send_beat(16'd20000, 16'd20000);
        send_beat(16'd9000, 16'd4000);
        send_beat(16'd20000, 16'd20000);
    endtask

    task automatic test_field_extremes();
        send_beat(16'h0000, 16'h0000);
        send_beat(16'hFFFF, 16'hFFFF);
        send_beat(16'h0000, 16'hFFFF);
        send_beat(16'hFFFF, 16'h0000);
    endtask

    // Zero period: integral frozen, derivative pinned by the sign of the change
    task automatic test_zero_dt();
        set_config(RST_KP, RST_KI, RST_KD, 16'd0, RST_FSAFE, RST_BSAFE, RST_TARGET,
                   RST_MAXSPD);
        send_beat(16'd30000, 16'd30000);
        send_beat(16'd30000, 16'd30000);
        send_beat(16'd30000, 16'd10000);
        send_beat(16'd30000, 16'd30000);
    endtask

    // Clamp below 50, at 50, and past 500
    task automatic test_speed_clamp();
        set_config(16'hFFFF, RST_KI, RST_KD, RST_DT, RST_FSAFE, RST_BSAFE, RST_TARGET, 9'd0);
        send_beat(16'd7680, 16'd7680);
        send_beat(16'd30000, 16'd30000);
        set_config(16'hFFFF, RST_KI, RST_KD, RST_DT, RST_FSAFE, RST_BSAFE, RST_TARGET, 9'd50);
        send_beat(16'd7700, 16'd7700);
        send_beat(16'd30000, 16'd30000);
        set_config(16'hFFFF, RST_KI, RST_KD, RST_DT, RST_FSAFE, RST_BSAFE, RST_TARGET, 9'd511);
        send_beat(16'd30000, 16'd4000);
        send_beat(16'd4000, 16'd60000);
    endtask

    // Smallest period with full D gain drives the derivative into saturation
    task automatic test_derivative_saturation();
        set_config(RST_KP, RST_KI, 16'hFFFF, 16'd1, RST_FSAFE, RST_BSAFE, RST_TARGET, 9'd500);
        send_beat(16'd7680, 16'd7680);
        send_beat(16'd60000, 16'd60000);
        send_beat(16'd7680, 16'd7680);
    endtask

    // Large steady error until the integral hits its upper bound
    task automatic test_integral_windup();
        set_config(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 9'd511);
        repeat (160) send_beat(16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)));
    endtask

    // Long receiver hold-off while the sender keeps offering beats
    task automatic test_output_hold();
        set_config(RST_KP, RST_KI, RST_KD, RST_DT, RST_FSAFE, RST_BSAFE, RST_TARGET,
                   RST_MAXSPD);
        tx_idle_on = 1'b0;
        hold_left = 400;
        repeat (8) send_beat(near_value(RST_TARGET, 3000), near_value(RST_TARGET, 3000));
        tx_idle_on = 1'b1;
        wait_drain();
    endtask

    task automatic run_random_phase(input int n_items);
        logic [15:0] fd, bd;
        int sel;
        repeat (n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                fd = near_value(gain_cfg.setpoint, 3000);
                bd = near_value(gain_cfg.setpoint, 3000);
            end else if (sel < 75) begin
                fd = near_value(gain_cfg.front_safety, 600);
                bd = near_value(gain_cfg.back_safety, 600);
            end else begin
                fd = 16'($urandom_range(0, 65535));
                bd = 16'($urandom_range(0, 65535));
            end
            send_beat(fd, bd);
        end
    endtask

    // Several register settings, extremes first, then random ones
    task automatic test_random_phases();
        int ph;
        for (ph = 0; ph < 6; ph++) begin
            tx_idle_on = (ph != 2);
            rx_idle_on = (ph != 3);
            if (ph == 0) begin
                set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0, 16'd0, 9'd511);
            end else if (ph == 1) begin
                set_config(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 9'd50);
            end else begin
                set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 10000)), 16'($urandom_range(0, 10000)),
                           16'($urandom_range(2000, 40000)), 9'($urandom_range(0, 511)));
            end
            run_random_phase(40);
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Main sequence
    initial begin
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_valid <= 1'b0;
        i_front_distance <= '0;
        i_back_distance <= '0;

        gain_cfg.kp = RST_KP;
        gain_cfg.ki = RST_KI;
        gain_cfg.kd = RST_KD;
        gain_cfg.dt = RST_DT;
        gain_cfg.front_safety = RST_FSAFE;
        gain_cfg.back_safety = RST_BSAFE;
        gain_cfg.setpoint = RST_TARGET;
        gain_cfg.speed_cap = RST_MAXSPD;
        integ_acc = 0;
        err_prev = 0;
        heading = DIR_STOP;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_direction_rules();
        test_field_extremes();
        test_zero_dt();
        test_speed_clamp();
        test_derivative_saturation();
        test_output_hold();
        test_integral_windup();
        test_random_phases();
        wait_drain();

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/dhpd_pkg.sv
sv/dhpd_regs.sv
sv/dhpd_div.sv
sv/dhpd_dp.sv
sv/dhpd_ctrl.sv
sv/distance_hold_pid_drive_unit.sv
sv/dhpd_checker.sv
dv/tb_distance_hold_pid_drive_unit.sv
